>>> design/mer_pkg.sv
// Shared types and codes for the midpoint ellipse rasterizer.
package mer_pkg;

    // Input item kinds, carried on s_tuser
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQ_RX,
        OP_SQ_RY,
        OP_MUL_RXSQ_RY,
        OP_INIT_ACC,
        OP_ROUND,
        OP_SW_RY_TX,
        OP_SQUARE,
        OP_SW_RX_TY,
        OP_SW_RX_RY,
        OP_SW_FIN,
        OP_STEP1,
        OP_STEP2
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ_RX,
        ST_SQ_RY,
        ST_MUL_RY,
        ST_INIT_ACC,
        ST_ROUND_INIT,
        ST_SW_SQ_A,
        ST_SW_RX_TY,
        ST_SW_SQ_B,
        ST_SW_RX_RY,
        ST_SW_SQ_C,
        ST_SW_FIN,
        ST_SW_ROUND,
        ST_STEP2,
        ST_EMIT,
        ST_EMIT_NULL
    } ctl_state_t;

    typedef struct packed {
        dp_op_t op;
        logic   emit;
        logic   emit_null;
    } dp_cmd_t;

    typedef struct packed {
        logic active;
        logic in_region_two;
        logic sx_below_sy;
        logic out_free;
    } dp_status_t;

endpackage

>>> design/mer_ctrl.sv
// Sequencer for the ellipse rasterizer: item dispatch and multi-cycle op sequences.
module mer_ctrl import mer_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic       s_tuser,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctl_state_t state_reg, state_next;
    ctl_state_t disp_state;
    dp_op_t     disp_op;
    logic       accept;

    assign accept = s_tvalid && s_tready;

    // Where an accepted item goes, given the walk state left by the previous item
    always_comb begin
        disp_state = ST_IDLE;
        disp_op    = OP_NONE;
        if (s_tuser == ACT_START) begin
            disp_state = ST_SQ_RX;
            disp_op    = OP_LOAD;
        end else if (!status.active) begin
            disp_state = ST_EMIT_NULL;
            disp_op    = OP_NONE;
        end else if (status.in_region_two) begin
            disp_state = ST_EMIT;
            disp_op    = OP_STEP2;
        end else if (status.sx_below_sy) begin
            disp_state = ST_EMIT;
            disp_op    = OP_STEP1;
        end else begin
            disp_state = ST_SW_SQ_A;
            disp_op    = OP_SW_RY_TX;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) state_next = disp_state;
            end
            ST_SQ_RX:      state_next = ST_SQ_RY;
            ST_SQ_RY:      state_next = ST_MUL_RY;
            ST_MUL_RY:     state_next = ST_INIT_ACC;
            ST_INIT_ACC:   state_next = ST_ROUND_INIT;
            ST_ROUND_INIT: state_next = ST_EMIT;
            ST_SW_SQ_A:    state_next = ST_SW_RX_TY;
            ST_SW_RX_TY:   state_next = ST_SW_SQ_B;
            ST_SW_SQ_B:    state_next = ST_SW_RX_RY;
            ST_SW_RX_RY:   state_next = ST_SW_SQ_C;
            ST_SW_SQ_C:    state_next = ST_SW_FIN;
            ST_SW_FIN:     state_next = ST_SW_ROUND;
            ST_SW_ROUND:   state_next = ST_STEP2;
            ST_STEP2:      state_next = ST_EMIT;
            ST_EMIT, ST_EMIT_NULL: begin
                if (status.out_free) state_next = accept ? disp_state : ST_IDLE;
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready      = 1'b0;
        cmd.op        = OP_NONE;
        cmd.emit      = 1'b0;
        cmd.emit_null = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.op   = accept ? disp_op : OP_NONE;
            end
            ST_EMIT, ST_EMIT_NULL: begin
                // next item enters in the same cycle the finished one is registered
                s_tready      = status.out_free;
                cmd.op        = accept ? disp_op : OP_NONE;
                cmd.emit      = (state_reg == ST_EMIT) && status.out_free;
                cmd.emit_null = (state_reg == ST_EMIT_NULL) && status.out_free;
            end
            ST_SQ_RX:      cmd.op = OP_SQ_RX;
            ST_SQ_RY:      cmd.op = OP_SQ_RY;
            ST_MUL_RY:     cmd.op = OP_MUL_RXSQ_RY;
            ST_INIT_ACC:   cmd.op = OP_INIT_ACC;
            ST_ROUND_INIT: cmd.op = OP_ROUND;
            ST_SW_SQ_A:    cmd.op = OP_SQUARE;
            ST_SW_RX_TY:   cmd.op = OP_SW_RX_TY;
            ST_SW_SQ_B:    cmd.op = OP_SQUARE;
            ST_SW_RX_RY:   cmd.op = OP_SW_RX_RY;
            ST_SW_SQ_C:    cmd.op = OP_SQUARE;
            ST_SW_FIN:     cmd.op = OP_SW_FIN;
            ST_SW_ROUND:   cmd.op = OP_ROUND;
            ST_STEP2:      cmd.op = OP_STEP2;
            default:       cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> design/mer_datapath.sv
// Datapath of the ellipse rasterizer: walk registers, shared multiplier, output register.
module mer_datapath import mer_pkg::*; #(
    parameter  int COORD_BITS = 10,
    localparam int RAD_BITS   = COORD_BITS - 1,
    localparam int IN_BITS    = ((2 * COORD_BITS + 2 * RAD_BITS + 7) / 8) * 8,
    localparam int OUT_BITS   = COORD_BITS + 2,
    localparam int M_BITS     = ((4 * OUT_BITS + 7) / 8) * 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [IN_BITS-1:0] s_tdata,
    input  dp_cmd_t            cmd,
    output dp_status_t         status,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [M_BITS-1:0]  m_tdata,
    output logic               m_tuser,
    output logic               m_tlast
);

    localparam int SQ_BITS    = 2 * RAD_BITS;
    localparam int SLOPE_BITS = COORD_BITS + SQ_BITS + 1;
    localparam int MUL_BITS   = 2 * COORD_BITS;
    localparam int PROD_BITS  = 2 * MUL_BITS;
    localparam int ACC_BITS   = PROD_BITS + 3;
    localparam int DEC_BITS   = PROD_BITS + 1;

    logic [COORD_BITS-1:0]      cx_reg, cx_next, cy_reg, cy_next;
    logic [RAD_BITS-1:0]        rx_reg, rx_next, ry_reg, ry_next;
    logic [COORD_BITS-1:0]      x_reg, x_next, y_reg, y_next;
    logic [SQ_BITS-1:0]         rx_sq_reg, rx_sq_next, ry_sq_reg, ry_sq_next;
    logic [SLOPE_BITS-1:0]      sx_reg, sx_next, sy_reg, sy_next;
    logic signed [DEC_BITS-1:0] dec_reg, dec_next;
    logic signed [ACC_BITS-1:0] acc_reg, acc_next;
    logic [PROD_BITS-1:0]       prod_reg, prod_next;
    logic                       active_reg, active_next, r2_reg, r2_next;
    logic                       m_valid_reg, m_valid_next;
    logic [M_BITS-1:0]          m_data_reg, m_data_next;
    logic                       m_user_reg, m_user_next, m_last_reg, m_last_next;

    logic [MUL_BITS-1:0]        mul_a, mul_b;
    logic [SLOPE_BITS-1:0]      sx_step, sy_step;
    logic signed [DEC_BITS-1:0] sx_ext, sy_ext, rx_sq_ext, ry_sq_ext, dec_rounded;
    logic signed [ACC_BITS-1:0] prod4;
    logic [ACC_BITS-1:0]        acc_mag, acc_round;
    logic [COORD_BITS-1:0]      y_dec;
    logic [OUT_BITS-1:0]        x_right, x_left, y_top, y_bottom;
    logic                       out_free;

    assign out_free = !m_valid_reg || m_tready;

    assign status.active        = active_reg;
    assign status.in_region_two = r2_reg;
    assign status.sx_below_sy   = sx_reg < sy_reg;
    assign status.out_free      = out_free;

    assign y_dec     = y_reg - COORD_BITS'(1);
    assign sx_step   = sx_reg + SLOPE_BITS'({ry_sq_reg, 1'b0});
    assign sy_step   = sy_reg - SLOPE_BITS'({rx_sq_reg, 1'b0});
    assign sx_ext    = $signed(DEC_BITS'(sx_step));
    assign sy_ext    = $signed(DEC_BITS'(sy_step));
    assign rx_sq_ext = $signed(DEC_BITS'(rx_sq_reg));
    assign ry_sq_ext = $signed(DEC_BITS'(ry_sq_reg));
    assign prod4     = $signed(ACC_BITS'({prod_reg, 2'b00}));

    // quarter units to integer, halves away from zero
    assign acc_mag     = acc_reg[ACC_BITS-1] ? $unsigned(-acc_reg) : $unsigned(acc_reg);
    assign acc_round   = (acc_mag + ACC_BITS'(2)) >> 2;
    assign dec_rounded = acc_reg[ACC_BITS-1] ? -$signed(DEC_BITS'(acc_round))
                                             :  $signed(DEC_BITS'(acc_round));

    // the one multiplier; the second-region value is built from squares of short products
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_SQ_RX: begin
                mul_a = MUL_BITS'(rx_reg);
                mul_b = MUL_BITS'(rx_reg);
            end
            OP_SQ_RY: begin
                mul_a = MUL_BITS'(ry_reg);
                mul_b = MUL_BITS'(ry_reg);
            end
            OP_MUL_RXSQ_RY: begin
                mul_a = MUL_BITS'(rx_sq_reg);
                mul_b = MUL_BITS'(ry_reg);
            end
            OP_SW_RY_TX: begin
                mul_a = MUL_BITS'(ry_reg);
                mul_b = MUL_BITS'({x_reg, 1'b1});
            end
            OP_SQUARE: begin
                mul_a = prod_reg[MUL_BITS-1:0];
                mul_b = prod_reg[MUL_BITS-1:0];
            end
            OP_SW_RX_TY: begin
                mul_a = MUL_BITS'(rx_reg);
                mul_b = MUL_BITS'(y_dec);
            end
            OP_SW_RX_RY: begin
                mul_a = MUL_BITS'(rx_reg);
                mul_b = MUL_BITS'(ry_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        rx_next     = rx_reg;
        ry_next     = ry_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        rx_sq_next  = rx_sq_reg;
        ry_sq_next  = ry_sq_reg;
        sx_next     = sx_reg;
        sy_next     = sy_reg;
        dec_next    = dec_reg;
        acc_next    = acc_reg;
        prod_next   = mul_a * mul_b;
        active_next = active_reg;
        r2_next     = r2_reg;
        case (cmd.op)
            OP_NONE: begin
                prod_next = prod_reg;
            end
            OP_LOAD: begin
                cx_next     = s_tdata[COORD_BITS-1:0];
                cy_next     = s_tdata[2*COORD_BITS-1:COORD_BITS];
                rx_next     = s_tdata[2*COORD_BITS+RAD_BITS-1:2*COORD_BITS];
                ry_next     = s_tdata[2*COORD_BITS+2*RAD_BITS-1:2*COORD_BITS+RAD_BITS];
                x_next      = '0;
                y_next      = COORD_BITS'(ry_next);
                sx_next     = '0;
                r2_next     = 1'b0;
                active_next = (ry_next != '0);
            end
            OP_SQ_RY:       rx_sq_next = prod_reg[SQ_BITS-1:0];
            OP_MUL_RXSQ_RY: ry_sq_next = prod_reg[SQ_BITS-1:0];
            OP_INIT_ACC: begin
                sy_next  = SLOPE_BITS'({prod_reg, 1'b0});
                acc_next = $signed(ACC_BITS'({ry_sq_reg, 2'b00}))
                         + $signed(ACC_BITS'(rx_sq_reg)) - prod4;
            end
            OP_ROUND:    dec_next = dec_rounded;
            OP_SW_RY_TX: r2_next  = 1'b1;
            OP_SW_RX_TY: acc_next = $signed(ACC_BITS'(prod_reg));
            OP_SW_RX_RY: acc_next = acc_reg + prod4;
            OP_SW_FIN:   acc_next = acc_reg - prod4;
            OP_STEP1: begin
                x_next  = x_reg + COORD_BITS'(1);
                sx_next = sx_step;
                if (dec_reg < 0) begin
                    dec_next = dec_reg + sx_ext + ry_sq_ext;
                end else begin
                    y_next   = y_dec;
                    sy_next  = sy_step;
                    dec_next = dec_reg + sx_ext - sy_ext + ry_sq_ext;
                end
                active_next = (y_next != '0);
            end
            OP_STEP2: begin
                y_next  = y_dec;
                sy_next = sy_step;
                if (dec_reg > 0) begin
                    dec_next = dec_reg + rx_sq_ext - sy_ext;
                end else begin
                    x_next   = x_reg + COORD_BITS'(1);
                    sx_next  = sx_step;
                    dec_next = dec_reg + rx_sq_ext + sx_ext - sy_ext;
                end
                active_next = (y_dec != '0);
            end
            default: begin
                // squaring ops only load the product register
                prod_next = mul_a * mul_b;
            end
        endcase
    end

    assign x_right  = OUT_BITS'(cx_reg) + OUT_BITS'(x_reg);
    assign x_left   = OUT_BITS'(cx_reg) - OUT_BITS'(x_reg);
    assign y_top    = OUT_BITS'(cy_reg) + OUT_BITS'(y_reg);
    assign y_bottom = OUT_BITS'(cy_reg) - OUT_BITS'(y_reg);

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_last_next  = m_last_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
            m_data_next  = M_BITS'({y_bottom, y_top, x_left, x_right});
            m_user_next  = 1'b1;
            m_last_next  = (y_reg == '0);
        end else if (cmd.emit_null) begin
            m_valid_next = 1'b1;
            m_data_next  = '0;
            m_user_next  = 1'b0;
            m_last_next  = 1'b0;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            r2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            active_reg  <= active_next;
            r2_reg      <= r2_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        rx_reg     <= rx_next;
        ry_reg     <= ry_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        rx_sq_reg  <= rx_sq_next;
        ry_sq_reg  <= ry_sq_next;
        sx_reg     <= sx_next;
        sy_reg     <= sy_next;
        dec_reg    <= dec_next;
        acc_reg    <= acc_next;
        prod_reg   <= prod_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

>>> design/midpoint_ellipse_rasterizer_core.sv
// Top level of the midpoint ellipse rasterizer.
//
// A start item (s_tuser 0) latches center and radii and produces the point (0, radius_y);
// each step item (s_tuser 1) advances one midpoint iteration and produces the next point
// with its three mirror images, the final one flagged on m_tlast. A step with no ellipse
// in progress returns an item with m_tuser 0 and zero data. Exactly one result item per
// input item. Step items stream at one per clock while m_tready holds, except the step
// that crosses from region one to region two, which holds off the input as a start does;
// both run a sequence of states on the single shared multiplier, which forms the
// squared radii and the decision values one product per cycle.
module midpoint_ellipse_rasterizer_core import mer_pkg::*; #(
    parameter  int COORD_BITS = 10,
    localparam int RAD_BITS   = COORD_BITS - 1,
    localparam int IN_BITS    = ((2 * COORD_BITS + 2 * RAD_BITS + 7) / 8) * 8,
    localparam int OUT_BITS   = COORD_BITS + 2,
    localparam int M_BITS     = ((4 * OUT_BITS + 7) / 8) * 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [IN_BITS-1:0] s_tdata,  // center_x, center_y, radius_x, radius_y
    input  logic               s_tuser,  // action
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [M_BITS-1:0]  m_tdata,  // x_right, x_left, y_top, y_bottom
    output logic               m_tuser,  // valid_res
    output logic               m_tlast
);

    dp_cmd_t    cmd;
    dp_status_t status;

    mer_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    mer_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // a start occupies the multiplier through its state sequence
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == ACT_START) |=> !s_tready)
        else $error("item accepted during start sequence");

    a_null_item: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata == '0) && !m_tlast)
        else $error("empty result carries data");

    a_last_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("last flag on empty result");

    // the last point ends the walk
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit && !status.active && (cmd.op == OP_NONE) |=> m_tlast)
        else $error("walk ended without last point");

endmodule
